### hw/rtl/block_rms_level_meter_assert.svh
// assertion macros for the block rms level meter
`ifndef BLOCK_RMS_LEVEL_METER_ASSERT_SVH
`define BLOCK_RMS_LEVEL_METER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/brlm_pkg.sv
// shared constants and types for the block rms level meter
package brlm_pkg;

  localparam int MAX_BLOCK  = 512;
  localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 64;
  localparam int HALF_W     = SUM_W / 2;
  localparam int LEVEL_W    = 8;
  localparam int SQ_W       = 2 * LEVEL_W;
  localparam int NEED_W     = CNT_W + SQ_W;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT
  } brlm_state_t;

endpackage

### hw/rtl/block_rms_level_meter.sv
// top level of the block rms level meter
// Accumulates the squares of signed 32-bit samples and, at the end of each block (sample
// with tlast set, or the MAX_BLOCK-th sample), emits one word holding the level
// floor(sqrt(mean square)/65536) clamped to 255; the sum saturates at 2^64-1. Each sample
// is accepted, passed through the 4-bit digit-serial squarer and the 64-bit accumulate,
// then checked for block end. Closing a block adds the root search (per level bit a
// square step, then a count multiply and compare) and a load of the output register,
// which waits until it is free. A finished level waits in that register while the next
// samples are accepted.
module block_rms_level_meter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [brlm_pkg::SAMPLE_W-1:0]  in_tdata,  // [31:0] sample
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [brlm_pkg::LEVEL_W-1:0]   out_tdata  // [7:0] level
);
  import brlm_pkg::*;

`include "block_rms_level_meter_assert.svh"

  brlm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic               close;
  logic               sq_start;
  logic               sq_clr;
  logic               sq_busy;
  logic [SUM_W-1:0]   sq_sum;
  logic               root_start;
  logic               root_busy;
  logic [LEVEL_W-1:0] root_level;

  brlm_sq_acc u_sq_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .clr    (sq_clr),
    .sample (in_tdata),
    .busy   (sq_busy),
    .sum    (sq_sum)
  );

  brlm_root u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (root_start),
    .sum_hi (sq_sum[SUM_W-1:HALF_W]),
    .count  (cnt_inc),
    .busy   (root_busy),
    .level  (root_level)
  );

  assign cnt_inc = cnt_r + 1'b1;
  assign close   = last_r || (cnt_inc >= CNT_W'(MAX_BLOCK));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    sq_start      = 1'b0;
    sq_clr        = 1'b0;
    root_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sq_start  = 1'b1;
          last_nxt  = in_tlast;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (!sq_busy) begin
          if (close) begin
            root_start = 1'b1;
            sq_clr     = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = ST_ROOT;
          end else begin
            cnt_nxt   = cnt_inc;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ROOT: begin
        if (!root_busy && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = root_level;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_r < CNT_W'(MAX_BLOCK), "sample count out of range")
  `ASSERT_IMPLIES(a_units_exclusive, sq_busy, !root_busy, "squarer and root search overlap")
  `ASSERT_NEXT(a_sum_cleared, root_start, sq_sum == '0, "sum not cleared at block end")
  `ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, sq_busy, "accepted word not squared")

endmodule

### hw/rtl/brlm_sq_acc.sv
// digit-serial squarer with saturating sum-of-squares accumulator
module brlm_sq_acc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          clr,
  input  logic [brlm_pkg::SAMPLE_W-1:0] sample,
  output logic                          busy,
  output logic [brlm_pkg::SUM_W-1:0]    sum
);
  import brlm_pkg::*;

  logic [SAMPLE_W-1:0]         magnitude;
  logic [SAMPLE_W-1:0]         mcand_r;
  logic [SAMPLE_W-1:0]         digits_r;
  logic [SUM_W-1:0]            prod_r;
  logic [SUM_W-1:0]            sum_r;
  logic [DIG_CNT_W-1:0]        dig_cnt_r;
  logic                        mul_r;
  logic                        add_r;
  logic [SAMPLE_W+DIGIT_W-1:0] pp;
  logic [SUM_W:0]              acc_sum;

  // two's complement magnitude, most negative value maps to 2^31 unsigned
  assign magnitude = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign pp        = mcand_r * digits_r[SAMPLE_W-1 -: DIGIT_W];
  assign acc_sum   = {1'b0, sum_r} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r     <= 1'b0;
      add_r     <= 1'b0;
      dig_cnt_r <= '0;
      sum_r     <= '0;
    end else begin
      if (start) begin
        mcand_r   <= magnitude;
        digits_r  <= magnitude;
        prod_r    <= '0;
        dig_cnt_r <= '0;
        mul_r     <= 1'b1;
      end else if (mul_r) begin
        prod_r    <= {prod_r[SUM_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + SUM_W'(pp);
        digits_r  <= digits_r << DIGIT_W;
        dig_cnt_r <= dig_cnt_r + 1'b1;
        if (dig_cnt_r == DIG_CNT_W'(NUM_DIGITS - 1)) begin
          mul_r <= 1'b0;
          add_r <= 1'b1;
        end
      end
      if (add_r) begin
        sum_r <= acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
        add_r <= 1'b0;
      end
      if (clr) begin
        sum_r <= '0;
      end
    end
  end

  assign busy = mul_r | add_r;
  assign sum  = sum_r;

endmodule

### hw/rtl/brlm_root.sv
// bitwise root search for the block level, each bit a square step and then a compare step
module brlm_root (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [brlm_pkg::HALF_W-1:0]  sum_hi,
  input  logic [brlm_pkg::CNT_W-1:0]   count,
  output logic                         busy,
  output logic [brlm_pkg::LEVEL_W-1:0] level
);
  import brlm_pkg::*;

  logic [HALF_W-1:0]  hi_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEVEL_W-1:0] lv_r;
  logic [LEVEL_W-1:0] bit_r;
  logic [SQ_W-1:0]    sq_r;
  logic               cmp_r;
  logic               busy_r;
  logic [LEVEL_W-1:0] trial;
  logic [NEED_W-1:0]  need;
  logic               fits;

  assign trial = lv_r | bit_r;
  assign need  = cnt_r * sq_r;
  assign fits  = HALF_W'(need) <= hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cmp_r  <= 1'b0;
    end else begin
      if (start) begin
        hi_r   <= sum_hi;
        cnt_r  <= count;
        lv_r   <= '0;
        bit_r  <= {1'b1, {(LEVEL_W-1){1'b0}}};
        cmp_r  <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!cmp_r) begin
          sq_r  <= {{LEVEL_W{1'b0}}, trial} * {{LEVEL_W{1'b0}}, trial};
          cmp_r <= 1'b1;
        end else begin
          if (fits) begin
            lv_r <= trial;
          end
          bit_r <= bit_r >> 1;
          cmp_r <= 1'b0;
          if (bit_r[0]) begin
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

  assign busy  = busy_r;
  assign level = lv_r;

endmodule

### sim/tb_block_rms_level_meter.sv
`timescale 1ns / 100ps
// testbench for the block rms level meter: sample blocks checked against a level predictor
module tb_block_rms_level_meter;
  import brlm_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_pattern_t;
  typedef enum int {SMP_LEVEL, SMP_ANY, SMP_QUIET, SMP_HOT} smp_style_t;

  class rms_level_tracker;
    logic [SUM_W-1:0] square_sum;
    int unsigned sample_count;
    logic [LEVEL_W-1:0] expected_levels[$];
    int unsigned failures;
    int unsigned reports;

    function new();
      square_sum = '0;
      sample_count = 0;
      failures = 0;
      reports = 0;
    endfunction

    // largest level with count * 2^32 * level^2 <= sum, saturated sum reads full scale
    function logic [LEVEL_W-1:0] root_search(logic [SUM_W-1:0] sum, int unsigned n);
      logic [SUM_W-1:0] scale;
      logic [SUM_W-1:0] trial;
      logic [SUM_W-1:0] need;
      logic [LEVEL_W-1:0] lv;
      lv = '0;
      if (&sum) return '1;
      scale = SUM_W'(n) << 32;
      for (int b = LEVEL_W - 1; b >= 0; b--) begin
        trial = SUM_W'(lv) | (SUM_W'(1) << b);
        need = scale * (trial * trial);
        if (need <= sum) lv = trial[LEVEL_W-1:0];
      end
      return lv;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic last);
      logic [SAMPLE_W-1:0] mag;
      logic [SUM_W-1:0] sq;
      logic [SUM_W:0] wide;
      int unsigned n;
      mag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
      sq = SUM_W'(mag) * SUM_W'(mag);
      wide = {1'b0, square_sum} + {1'b0, sq};
      if (wide[SUM_W]) wide[SUM_W-1:0] = '1;
      n = sample_count + 1;
      if (last || n >= MAX_BLOCK) begin
        expected_levels.push_back(root_search(wide[SUM_W-1:0], n));
        square_sum = '0;
        sample_count = 0;
      end else begin
        square_sum = wide[SUM_W-1:0];
        sample_count = n;
      end
    endfunction

    function void check_level(logic [LEVEL_W-1:0] got);
      logic [LEVEL_W-1:0] want;
      if (expected_levels.size() == 0) begin
        failures++;
        if (reports < 10) begin
          reports++;
          $display("level word %0d arrived with none pending", got);
        end
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) begin
        failures++;
        if (reports < 10) begin
          reports++;
          $display("level mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [LEVEL_W-1:0]  out_tdata;

  bit                  in_fire = 1'b0;
  int unsigned         burst_left = 0;
  rx_pattern_t         rx_mode = RX_OPEN;
  int unsigned         rx_phase_left = 0;
  int unsigned         rx_hold_left = 0;
  rms_level_tracker    meter = new();

  block_rms_level_meter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) meter.note_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) meter.check_level(out_tdata);
    end
  end

  // receiver back-pressure, switching between patterns
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(20, 200);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold_left != 0) begin
          rx_hold_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          rx_hold_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample(smp_style_t style);
    logic [SAMPLE_W-1:0] v;
    case (style)
      SMP_LEVEL: v = ($urandom_range(0, 300) << 16) + $urandom_range(0, 65535);
      SMP_QUIET: v = $urandom_range(0, 131071);
      SMP_HOT: v = 32'h7FFF_FFFF - $urandom_range(0, 4095);
      default: v = $urandom();
    endcase
    if (style != SMP_ANY && $urandom_range(0, 1)) v = -v;
    if (style == SMP_HOT && $urandom_range(0, 3) == 0) v = 32'h8000_0000;
    return v;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tlast <= last;
    do @(negedge clk); while (!in_fire);
  endtask

  initial begin
    int unsigned short_sent;
    int unsigned len;
    bit          long_done;
    bit          noisy;
    smp_style_t  style;
    short_sent = 0;
    long_done = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-sample blocks around level boundaries and clamp
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_FFFF, 1'b1);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'hFFFF_0000, 1'b1);
    send_sample(32'h00FF_0000, 1'b1);
    send_sample(32'h00FF_FFFF, 1'b1);
    send_sample(32'h0100_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b1);
    // four most negative samples overflow the sum
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    // a block below one step, then one between one and two steps
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFE_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b1);

    while (short_sent < 70) begin
      if (!long_done && short_sent >= 30) begin
        // unmarked run past the block length limit
        for (int i = 0; i < MAX_BLOCK + 2; i++)
          send_sample(pick_sample(SMP_LEVEL), i == MAX_BLOCK + 1);
        long_done = 1'b1;
      end
      style = smp_style_t'($urandom_range(0, 3));
      noisy = ($urandom_range(0, 9) == 0);
      len = noisy ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        send_sample(pick_sample(style), noisy ? ($urandom_range(0, 7) == 0) : (i == len - 1));
      short_sent += len;
    end
    in_tvalid <= 1'b0;

    while (meter.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (meter.failures == 0 && meter.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
